[hw/rtl/kwlah_pkg.sv]
// ----------------------------------------------------------------------------
// kwlah_pkg
// Shared types, constants and helper functions for the keyword lexer with an
// Adler-32 keyword table.
// ----------------------------------------------------------------------------
package kwlah_pkg;

  // Keyword table size and slot index width.
  localparam int unsigned KEYWORDS = 16;
  localparam int unsigned SLOT_W   = 4;

  // Adler-32 modulus.
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // Reset value of the comment byte ('#').
  localparam logic [7:0] COMMENT_RESET = 8'd35;

  // Depth of the result queue and its pointer width.
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = 2;

  // Character constants.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  // Input mode codes.
  localparam logic MODE_TEXT  = 1'b0;
  localparam logic MODE_TABLE = 1'b1;

  // Byte classes.
  typedef enum logic [2:0] {
    CL_OTHER,
    CL_DIGIT,
    CL_SEP,
    CL_QUOTE,
    CL_BLANK,
    CL_NEWLINE,
    CL_COMMENT
  } class_e;

  // Token kinds as reported on the output.
  typedef enum logic [2:0] {
    K_WORD    = 3'd0,
    K_KEYWORD = 3'd1,
    K_NUMBER  = 3'd2,
    K_BLANK   = 3'd3,
    K_NEWLINE = 3'd4,
    K_COMMENT = 3'd5,
    K_QUOTE   = 3'd6
  } kind_e;

  // One accepted input transaction.
  typedef struct packed {
    logic              mode;
    logic [7:0]        char_byte;
    logic [SLOT_W-1:0] slot;
    logic              key_valid;
    logic [31:0]       key_hash;
    logic [15:0]       key_id;
  } item_t;

  // One result token.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] keyword_id;
    logic [15:0] start_pos;
    logic [15:0] token_length;
    logic [15:0] token_number;
    logic        last;
  } res_t;

  // Outcome of the keyword table lookup.
  typedef struct packed {
    logic        hit;
    logic [15:0] id;
  } match_t;

  // Result queue status seen by the front end.
  typedef struct packed {
    logic                room;
    logic [RQ_PTR_W:0]   count;
  } rq_stat_t;

  // Sort one text byte into its class; the comment byte wins over all others.
  function automatic class_e classify(input logic [7:0] b, input logic [7:0] cmt);
    class_e cl;
    cl = CL_OTHER;
    if (b == cmt) begin
      cl = CL_COMMENT;
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      cl = CL_DIGIT;
    end else begin
      unique case (b)
        CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_SEMI: cl = CL_SEP;
        CH_DQUOTE:        cl = CL_QUOTE;
        CH_SPACE, CH_TAB: cl = CL_BLANK;
        CH_NL:            cl = CL_NEWLINE;
        default:          cl = CL_OTHER;
      endcase
    end
    return cl;
  endfunction

  // One Adler-32 step; both sums stay below the modulus, so a single
  // compare and subtract reduces each of them.
  function automatic logic [31:0] adler_add(input logic [15:0] lo, input logic [15:0] hi,
                                            input logic [7:0] b);
    logic [16:0] t1;
    logic [16:0] t2;
    t1 = {1'b0, lo} + {9'd0, b};
    if (t1 >= ADLER_MOD) begin
      t1 = t1 - ADLER_MOD;
    end
    t2 = {1'b0, hi} + t1;
    if (t2 >= ADLER_MOD) begin
      t2 = t2 - ADLER_MOD;
    end
    return {t2[15:0], t1[15:0]};
  endfunction

endpackage

[hw/rtl/keyword_lexer_adler_hash_core.sv]
// ----------------------------------------------------------------------------
// keyword_lexer_adler_hash_core
// Top level of the keyword lexer with an Adler-32 keyword table.
// ----------------------------------------------------------------------------
// The lexer takes one input transaction per cycle unless in_stall_o is set,
// either a text byte or a keyword table write, and returns tokens one per
// output transaction. An accepted byte is held in an input register,
// classified, matched against the sixteen-entry table in parallel and turned
// into at most two tokens once the result queue has room; those tokens go
// into a four-entry result queue that drives the output. Sustained input
// rate is one byte per cycle as long as the output takes one token per cycle
// and no byte yields two tokens; a byte that closes a run and is itself a
// one-byte token yields two tokens, and the output port then sets the limit.
// A configuration write changes the comment byte and is taken in any cycle;
// it is meant for times when no text is in flight.
module keyword_lexer_adler_hash_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [7:0]                   cfg_data_i,
  // Input channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [7:0]                   char_byte_i,
  input  logic [kwlah_pkg::SLOT_W-1:0] slot_i,
  input  logic                         key_valid_i,
  input  logic [31:0]                  key_hash_i,
  input  logic [15:0]                  key_id_i,
  // Output channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   token_kind_o,
  output logic [15:0]                  keyword_id_o,
  output logic [15:0]                  start_pos_o,
  output logic [15:0]                  token_length_o,
  output logic [15:0]                  token_number_o,
  output logic                         last_o
);
  import kwlah_pkg::*;

  logic        in_valid_q, in_valid_d;
  item_t       item_q;
  logic        accept;
  logic        fire;
  logic        pop;
  logic [7:0]  comment_char_q;
  logic [31:0] word_hash;
  match_t      match;
  res_t        res_a;
  res_t        res_b;
  logic [1:0]  push_cnt;
  res_t        head;
  rq_stat_t    rq_stat;

  // Configuration register, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_char_q <= COMMENT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      comment_char_q <= cfg_data_i;
    end
  end

  // Input register: refilled whenever it is empty or its item is processed.
  assign fire       = in_valid_q && rq_stat.room;
  assign in_stall_o = in_valid_q && !rq_stat.room;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.mode      <= mode_i;
      item_q.char_byte <= char_byte_i;
      item_q.slot      <= slot_i;
      item_q.key_valid <= key_valid_i;
      item_q.key_hash  <= key_hash_i;
      item_q.key_id    <= key_id_i;
    end
  end

  // Keyword table.
  kwlah_kw_table u_kw_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (fire && (item_q.mode == MODE_TABLE)),
    .item_i      (item_q),
    .word_hash_i (word_hash),
    .match_o     (match)
  );

  // Lexer state and token builder.
  kwlah_lexer u_lexer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .item_i         (item_q),
    .comment_char_i (comment_char_q),
    .match_i        (match),
    .word_hash_o    (word_hash),
    .res_a_o        (res_a),
    .res_b_o        (res_b),
    .push_cnt_o     (push_cnt)
  );

  // Result queue toward the output channel.
  assign pop = out_valid_o && !out_stall_i;

  kwlah_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_a_i    (res_a),
    .res_b_i    (res_b),
    .push_cnt_i (push_cnt),
    .pop_i      (pop),
    .valid_o    (out_valid_o),
    .head_o     (head),
    .stat_o     (rq_stat)
  );

  assign token_kind_o   = head.kind;
  assign keyword_id_o   = head.keyword_id;
  assign start_pos_o    = head.start_pos;
  assign token_length_o = head.token_length;
  assign token_number_o = head.token_number;
  assign last_o         = head.last;

  // The queue never holds more tokens than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_stat.count <= (RQ_PTR_W + 1)'(RQ_DEPTH))
    else $error("result queue overflow");

  // Input is only stalled while an item waits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  // A token that is not the last of its byte always has its partner queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |=> out_valid_o)
    else $error("second token of a byte missing");

  // Table writes and end-of-text bytes produce no tokens.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (item_q.mode == MODE_TABLE || item_q.char_byte == CH_NUL)) |-> push_cnt == 2'd0)
    else $error("tokens produced without a text byte");

endmodule

[hw/rtl/kwlah_kw_table.sv]
// ----------------------------------------------------------------------------
// kwlah_kw_table
// Flat keyword table: sixteen entries of valid flag, Adler-32 and identifier,
// with a parallel compare that returns the lowest matching valid entry.
// ----------------------------------------------------------------------------
module kwlah_kw_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  kwlah_pkg::item_t item_i,
  input  logic [31:0]     word_hash_i,
  output kwlah_pkg::match_t match_o
);
  import kwlah_pkg::*;

  logic [KEYWORDS-1:0] valid_q;
  logic [31:0]         hash_q [KEYWORDS];
  logic [15:0]         id_q   [KEYWORDS];

  // Valid flags are cleared at reset; an entry is only read when valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[item_i.slot] <= item_i.key_valid;
    end
  end

  // Hash and identifier storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      hash_q[item_i.slot] <= item_i.key_hash;
      id_q[item_i.slot]   <= item_i.key_id;
    end
  end

  // Parallel compare; scanning from the top lets the lowest slot win.
  always_comb begin
    match_o = '0;
    for (int i = KEYWORDS - 1; i >= 0; i--) begin
      if (valid_q[i] && hash_q[i] == word_hash_i) begin
        match_o.hit = 1'b1;
        match_o.id  = id_q[i];
      end
    end
  end

endmodule

[hw/rtl/kwlah_lexer.sv]
// ----------------------------------------------------------------------------
// kwlah_lexer
// Lexer state and token builder: classifies one byte, closes and opens runs,
// keeps the running Adler-32 sums and forms up to two tokens per byte.
// ----------------------------------------------------------------------------
module kwlah_lexer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  kwlah_pkg::item_t  item_i,
  input  logic [7:0]        comment_char_i,
  input  kwlah_pkg::match_t match_i,
  output logic [31:0]       word_hash_o,
  output kwlah_pkg::res_t   res_a_o,
  output kwlah_pkg::res_t   res_b_o,
  output logic [1:0]        push_cnt_o
);
  import kwlah_pkg::*;

  logic        in_word_q, in_word_d;
  logic        in_number_q, in_number_d;
  logic [15:0] run_start_q, run_start_d;
  logic [15:0] position_q, position_d;
  logic [15:0] token_cnt_q, token_cnt_d;
  logic [15:0] sum_low_q, sum_low_d;
  logic [15:0] sum_high_q, sum_high_d;

  class_e      cl;
  logic        text;
  logic        end_text;
  logic        close_word;
  logic        close_num;
  logic        has_run;
  logic        has_single;
  kind_e       run_kind;
  kind_e       single_kind;
  res_t        run_res;
  res_t        single_res;
  logic [15:0] base_low;
  logic [15:0] base_high;
  logic [31:0] sums_new;

  assign word_hash_o = {sum_high_q, sum_low_q};

  // Byte class and the runs it closes.
  always_comb begin
    cl         = classify(item_i.char_byte, comment_char_i);
    text       = (item_i.mode == MODE_TEXT);
    end_text   = text && (item_i.char_byte == CH_NUL);
    close_word = text && !end_text && in_word_q && (cl != CL_OTHER) && (cl != CL_DIGIT);
    close_num  = text && !end_text && in_number_q && (cl != CL_DIGIT);
    has_run    = close_word || close_num;
    has_single = text && !end_text &&
                 (cl == CL_NEWLINE || cl == CL_COMMENT || cl == CL_BLANK || cl == CL_QUOTE);
  end

  // Token kind of a one-byte token.
  always_comb begin
    unique case (cl)
      CL_NEWLINE: single_kind = K_NEWLINE;
      CL_COMMENT: single_kind = K_COMMENT;
      CL_BLANK:   single_kind = K_BLANK;
      default:    single_kind = K_QUOTE;
    endcase
  end

  // Build the run token and the one-byte token, run first when both exist.
  always_comb begin
    if (close_word) begin
      run_kind = match_i.hit ? K_KEYWORD : K_WORD;
    end else begin
      run_kind = K_NUMBER;
    end
    run_res.kind         = run_kind;
    run_res.keyword_id   = (close_word && match_i.hit) ? match_i.id : 16'd0;
    run_res.start_pos    = run_start_q;
    run_res.token_length = position_q - run_start_q;
    run_res.token_number = token_cnt_q;
    run_res.last         = !has_single;

    single_res.kind         = single_kind;
    single_res.keyword_id   = 16'd0;
    single_res.start_pos    = position_q;
    single_res.token_length = 16'd1;
    single_res.token_number = has_run ? (token_cnt_q + 16'd1) : token_cnt_q;
    single_res.last         = 1'b1;

    if (has_run) begin
      res_a_o = run_res;
    end else begin
      res_a_o = single_res;
    end
    res_b_o    = single_res;
    push_cnt_o = fire_i ? (2'(has_run) + 2'(has_single)) : 2'd0;
  end

  // Next lexer state.
  always_comb begin
    in_word_d   = in_word_q;
    in_number_d = in_number_q;
    run_start_d = run_start_q;
    position_d  = position_q;
    token_cnt_d = token_cnt_q;
    sum_low_d   = sum_low_q;
    sum_high_d  = sum_high_q;
    base_low    = in_word_q ? sum_low_q : 16'd1;
    base_high   = in_word_q ? sum_high_q : 16'd0;
    sums_new    = adler_add(base_low, base_high, item_i.char_byte);

    if (fire_i && end_text) begin
      in_word_d   = 1'b0;
      in_number_d = 1'b0;
      run_start_d = 16'd0;
      position_d  = 16'd0;
      token_cnt_d = 16'd0;
      sum_low_d   = 16'd1;
      sum_high_d  = 16'd0;
    end else if (fire_i && text) begin
      token_cnt_d = token_cnt_q + 16'(push_cnt_o);
      position_d  = position_q + 16'd1;
      if (close_word) begin
        in_word_d = 1'b0;
      end
      if (close_num) begin
        in_number_d = 1'b0;
      end
      if (cl == CL_OTHER) begin
        in_word_d  = 1'b1;
        sum_low_d  = sums_new[15:0];
        sum_high_d = sums_new[31:16];
        if (!in_word_q) begin
          run_start_d = position_q;
        end
      end else if (cl == CL_DIGIT) begin
        if (in_word_q) begin
          sum_low_d  = sums_new[15:0];
          sum_high_d = sums_new[31:16];
        end else if (!in_number_q) begin
          in_number_d = 1'b1;
          run_start_d = position_q;
        end
      end
    end
  end

  // Lexer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q   <= 1'b0;
      in_number_q <= 1'b0;
      run_start_q <= 16'd0;
      position_q  <= 16'd0;
      token_cnt_q <= 16'd0;
      sum_low_q   <= 16'd1;
      sum_high_q  <= 16'd0;
    end else begin
      in_word_q   <= in_word_d;
      in_number_q <= in_number_d;
      run_start_q <= run_start_d;
      position_q  <= position_d;
      token_cnt_q <= token_cnt_d;
      sum_low_q   <= sum_low_d;
      sum_high_q  <= sum_high_d;
    end
  end

endmodule

[hw/rtl/kwlah_res_fifo.sv]
// ----------------------------------------------------------------------------
// kwlah_res_fifo
// Result queue: takes up to two tokens per cycle and delivers one per output
// transaction. Room is reported when two more tokens fit.
// ----------------------------------------------------------------------------
module kwlah_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kwlah_pkg::res_t    res_a_i,
  input  kwlah_pkg::res_t    res_b_i,
  input  logic [1:0]         push_cnt_i,
  input  logic               pop_i,
  output logic               valid_o,
  output kwlah_pkg::res_t    head_o,
  output kwlah_pkg::rq_stat_t stat_o
);
  import kwlah_pkg::*;

  res_t                mem_q [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RQ_PTR_W:0]   count_q, count_d;

  assign valid_o      = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.room  = (count_q <= (RQ_PTR_W + 1)'(RQ_DEPTH - 2));

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + RQ_PTR_W'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + RQ_PTR_W'(pop_i);
    count_d  = count_q + (RQ_PTR_W + 1)'(push_cnt_i) - (RQ_PTR_W + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Token storage; the second token goes to the slot after the first.
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= res_a_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + RQ_PTR_W'(1)] <= res_b_i;
    end
  end

endmodule
